// ----- rtl/ushs_pkg.sv -----
// ----------------------------------------------------------------------------
// ushs_pkg
// Shared types and constants for the ungapped diagonal segment scanner.
// ----------------------------------------------------------------------------
package ushs_pkg;

  // Command codes
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_SCORE = 1'b1
  } cmd_t;

  localparam int LETTER_W    = 5;
  localparam int VALUE_W     = 8;
  localparam int SCORE_W     = 24;
  localparam int POS_W       = 16;
  // pair score plus bias fits in 9 signed bits
  localparam int TERM_W      = VALUE_W + 1;
  // running sum plus term, signed, with headroom
  localparam int ACC_W       = SCORE_W + 2;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [SCORE_W-1:0] SUM_MAX = {SCORE_W{1'b1}};

  // Input item
  typedef struct packed {
    cmd_t                       cmd;
    logic [LETTER_W-1:0]        query_letter;
    logic [LETTER_W-1:0]        target_letter;
    logic signed [VALUE_W-1:0]  table_value;
    logic signed [VALUE_W-1:0]  bias;
    logic                       last;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [SCORE_W-1:0] best_score;
    logic [POS_W-1:0]   hsp_start;
    logic [POS_W-1:0]   hsp_length;
  } out_item_t;

  // Classified score step handed from front to back
  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic                     last;
  } step_t;

endpackage

// ----- rtl/ungapped_diagonal_hsp_scan.sv -----
// Path: a score item reaches the segment tracker through the table read register
// and the queue; the result appears the cycle after its last pair is tracked.
// A table load takes effect for any score item transferred in a later cycle.
// Throughput: one item per cycle unless the queue fills or a held result stalls.
// Reset: synchronous active-low rst_n clears run state, queue and handshakes;
// the table memory is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
// ungapped_diagonal_hsp_scan
// Maximum-sum ungapped segment scan along one diagonal with a loadable
// substitution table.
// ----------------------------------------------------------------------------
module ungapped_diagonal_hsp_scan #(
  parameter int ALPHABET = 20,
  parameter int MAX_LEN  = 65535
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ushs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ushs_pkg::out_item_t out_data
);
  import ushs_pkg::*;

  logic  push;
  step_t push_data;
  logic  queue_full;
  logic  pop;
  logic  head_valid;
  step_t head_data;

  // Front end: loads and lookups
  ushs_front #(
    .ALPHABET (ALPHABET)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  // Decoupling queue
  ushs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // Back end: segment tracking and result
  ushs_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- rtl/ushs_front.sv -----
// ----------------------------------------------------------------------------
// ushs_front
// Accepts items, writes table loads, looks up the pair score for score
// steps and forms pair score plus bias for the back end.
// ----------------------------------------------------------------------------
module ushs_front #(
  parameter int ALPHABET = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ushs_pkg::in_item_t in_data,
  output logic               push,
  output ushs_pkg::step_t    push_data,
  input  logic               queue_full
);
  import ushs_pkg::*;

  localparam int QW     = $clog2(ALPHABET);
  localparam int ADDR_W = QW + LETTER_W;
  localparam int DEPTH  = ALPHABET * (2 ** LETTER_W);

  logic signed [VALUE_W-1:0] table_mem [DEPTH];

  logic                      accept;
  logic                      in_alpha;
  logic [ADDR_W-1:0]         addr;
  logic                      s1_valid_r, s1_valid_nxt;
  logic                      s1_hit_r;
  logic                      s1_last_r;
  logic signed [VALUE_W-1:0] s1_bias_r;
  logic signed [VALUE_W-1:0] s1_rd_r;
  logic signed [TERM_W-1:0]  pair_ext;

  // Input handshake: the lookup stage frees up when it can move into the queue
  assign in_ready = !s1_valid_r || !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = s1_valid_r && !queue_full;

  // Letters outside the alphabet neither load nor look up
  assign in_alpha = ({1'b0, in_data.query_letter} < (LETTER_W + 1)'(ALPHABET)) &&
                    ({1'b0, in_data.target_letter} < (LETTER_W + 1)'(ALPHABET));
  assign addr     = {in_data.query_letter[QW-1:0], in_data.target_letter};

  // Table memory: one write port for loads, one registered read for scores
  always_ff @(posedge clk) begin
    if (accept && in_alpha) begin
      unique case (in_data.cmd)
        CMD_LOAD:  table_mem[addr] <= in_data.table_value;
        CMD_SCORE: s1_rd_r         <= table_mem[addr];
        default: ;
      endcase
    end
  end

  // Lookup stage payload
  always_ff @(posedge clk) begin
    if (accept && in_data.cmd == CMD_SCORE) begin
      s1_hit_r  <= in_alpha;
      s1_last_r <= in_data.last;
      s1_bias_r <= in_data.bias;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (push) begin
      s1_valid_nxt = 1'b0;
    end
    if (accept && in_data.cmd == CMD_SCORE) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Out-of-alphabet pairs score zero; only the bias counts
  assign pair_ext       = s1_hit_r ? TERM_W'(s1_rd_r) : '0;
  assign push_data.term = pair_ext + TERM_W'(s1_bias_r);
  assign push_data.last = s1_last_r;

endmodule

// ----- rtl/ushs_queue.sv -----
// ----------------------------------------------------------------------------
// ushs_queue
// Small FIFO of classified score steps between the front and back ends.
// ----------------------------------------------------------------------------
module ushs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ushs_pkg::step_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output ushs_pkg::step_t head_data
);
  import ushs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  step_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entries[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/ushs_back.sv -----
// ----------------------------------------------------------------------------
// ushs_back
// Running-sum segment tracker: adds each step, keeps the best segment and
// drives the result register on the last pair of a diagonal.
// ----------------------------------------------------------------------------
module ushs_back #(
  parameter int MAX_LEN = 65535
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  ushs_pkg::step_t     head_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output ushs_pkg::out_item_t out_data
);
  import ushs_pkg::*;

  localparam logic [POS_W-1:0] LEN_CAP = POS_W'(MAX_LEN);

  logic [SCORE_W-1:0]     run_sum_r, run_sum_nxt;
  logic [SCORE_W-1:0]     best_r, best_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [POS_W-1:0]       run_start_r, run_start_nxt;
  logic [POS_W-1:0]       run_len_r, run_len_nxt;
  logic [POS_W-1:0]       best_start_r, best_start_nxt;
  logic [POS_W-1:0]       best_len_r, best_len_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r;
  logic signed [ACC_W-1:0] sum_raw;
  logic signed [ACC_W-1:0] sum_sat;
  logic                   emit;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    sat_inc = (v >= LEN_CAP) ? LEN_CAP : v + POS_W'(1);
  endfunction

  // A last step may go only when the result register is free or draining
  assign pop  = head_valid && (!head_data.last || !out_valid_r || out_ready);
  assign emit = pop && head_data.last;

  // Add the step and saturate at the top of the score range
  assign sum_raw = $signed({2'b00, run_sum_r}) + ACC_W'(head_data.term);
  assign sum_sat = (sum_raw > $signed({2'b00, SUM_MAX})) ?
                   $signed({2'b00, SUM_MAX}) : sum_raw;

  // Segment update
  always_comb begin
    run_sum_nxt    = run_sum_r;
    best_nxt       = best_r;
    pos_nxt        = pos_r;
    run_start_nxt  = run_start_r;
    run_len_nxt    = run_len_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    if (pop) begin
      priority if (sum_sat > $signed({2'b00, best_r})) begin
        run_sum_nxt    = sum_sat[SCORE_W-1:0];
        run_len_nxt    = sat_inc(run_len_r);
        best_nxt       = sum_sat[SCORE_W-1:0];
        best_start_nxt = run_start_r;
        best_len_nxt   = run_len_nxt;
      end else if (sum_sat > 0) begin
        run_sum_nxt = sum_sat[SCORE_W-1:0];
        run_len_nxt = sat_inc(run_len_r);
      end else begin
        run_sum_nxt   = '0;
        run_start_nxt = sat_inc(pos_r);
        run_len_nxt   = '0;
      end
      pos_nxt = sat_inc(pos_r);
    end
  end

  // Run state; cleared after the last pair of a diagonal
  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      run_sum_r    <= '0;
      best_r       <= '0;
      pos_r        <= '0;
      run_start_r  <= '0;
      run_len_r    <= '0;
      best_start_r <= '0;
      best_len_r   <= '0;
    end else begin
      run_sum_r    <= run_sum_nxt;
      best_r       <= best_nxt;
      pos_r        <= pos_nxt;
      run_start_r  <= run_start_nxt;
      run_len_r    <= run_len_nxt;
      best_start_r <= best_start_nxt;
      best_len_r   <= best_len_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.best_score <= best_nxt;
      out_data_r.hsp_start  <= best_start_nxt;
      out_data_r.hsp_length <= best_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/ushs_checker.sv -----
// ----------------------------------------------------------------------------
// ushs_checker
// Port-level checks on the segment scanner, bound to the top level.
// ----------------------------------------------------------------------------
module ushs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input ushs_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input ushs_pkg::out_item_t out_data
);
  import ushs_pkg::*;

  // A stalled input transfer holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A positive best score always has a nonempty segment, and vice versa
  a_len_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.best_score == '0) == (out_data.hsp_length == '0)))
    else $error("segment length and score disagree");

  // No segment means the start stays at zero
  a_empty_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.best_score == '0) |-> (out_data.hsp_start == '0))
    else $error("empty segment with nonzero start");

endmodule

bind ungapped_diagonal_hsp_scan ushs_checker u_ushs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
